>>> hw/rtl/http_response_head_parser_assert.svh
// Assertion macros shared by the HTTP response head parser modules.
`ifndef HTTP_RESPONSE_HEAD_PARSER_ASSERT_SVH
`define HTTP_RESPONSE_HEAD_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define HRHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define HRHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hrhp_pkg.sv
// Types, character constants and codes of the HTTP response head parser.
`timescale 1ns / 1ps
package hrhp_pkg;

  localparam int unsigned OutLenW = 16;
  localparam int unsigned CodeW   = 10;
  localparam int unsigned VerPrefixLen = 7;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_SP1      = 4'd1,
    PH_CODE     = 4'd2,
    PH_SP2      = 4'd3,
    PH_REASON   = 4'd4,
    PH_LINE     = 4'd5,
    PH_NAME     = 4'd6,
    PH_COLON_SP = 4'd7,
    PH_VALUE    = 4'd8,
    PH_ERROR    = 4'd9
  } phase_e;

  typedef enum logic [3:0] {
    CLS_VERSION     = 4'd0,
    CLS_SPACE       = 4'd1,
    CLS_CODE        = 4'd2,
    CLS_REASON      = 4'd3,
    CLS_LINE_END    = 4'd4,
    CLS_NAME        = 4'd5,
    CLS_COLON       = 4'd6,
    CLS_VALUE       = 4'd7,
    CLS_FINAL_CRLF  = 4'd8,
    CLS_AFTER_ERROR = 4'd9
  } class_e;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_STATUS_DONE  = 3'd1,
    EV_FIELD_DONE   = 3'd2,
    EV_HEADERS_DONE = 3'd3,
    EV_ERROR        = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_BAD_VERSION   = 3'd1,
    ERR_NO_SP_VERSION = 3'd2,
    ERR_NO_SP_CODE    = 3'd3,
    ERR_NO_SP_COLON   = 3'd4,
    ERR_CR_NO_LF      = 3'd5
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_message;
  } in_beat_t;

  typedef struct packed {
    class_e              byte_class;
    event_e              event_res;
    err_e                error_kind;
    logic [CodeW-1:0]    status_code;
    logic [OutLenW-1:0]  name_length;
    logic [OutLenW-1:0]  value_length;
  } out_beat_t;

  // Fixed part of the version string, "HTTP/1." in order.
  function automatic logic [7:0] ver_char(logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h48;
      3'd1:    ch = 8'h54;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h50;
      3'd4:    ch = 8'h2f;
      3'd5:    ch = 8'h31;
      3'd6:    ch = 8'h2e;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> hw/rtl/hrhp_if.sv
// Valid/ready channel interfaces for the parser's byte input and result output.
`timescale 1ns / 1ps
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_message;

  modport source (output valid, output data_byte, output new_message, input ready);
  modport sink   (input valid, input data_byte, input new_message, output ready);
endinterface

interface hrhp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_class;
  logic [2:0]  event_res;
  logic [2:0]  error_kind;
  logic [9:0]  status_code;
  logic [15:0] name_length;
  logic [15:0] value_length;

  modport source (output valid, output byte_class, output event_res, output error_kind,
                  output status_code, output name_length, output value_length,
                  input ready);
  modport sink   (input valid, input byte_class, input event_res, input error_kind,
                  input status_code, input name_length, input value_length,
                  output ready);
endinterface

>>> hw/rtl/hrhp_in_reg.sv
// Input register stage that captures one byte beat ahead of the parser step.
`timescale 1ns / 1ps
module hrhp_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  hrhp_pkg::in_beat_t beat_i,
  input  logic              adv_i,
  output logic              valid_o,
  output hrhp_pkg::in_beat_t beat_o
);
  import hrhp_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t beat_q;

  // The stage can take a beat when empty or when its content moves on now.
  assign ready_o = !valid_q || adv_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

>>> hw/rtl/hrhp_core.sv
// Parser state registers and the per-byte classification step.
`timescale 1ns / 1ps
module hrhp_core #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  hrhp_pkg::in_beat_t  beat_i,
  output hrhp_pkg::out_beat_t res_o
);
  import hrhp_pkg::*;
  `include "http_response_head_parser_assert.svh"

  localparam logic [LENGTH_WIDTH-1:0] LenMax = {LENGTH_WIDTH{1'b1}};

  phase_e                  phase_q, phase_d, c_phase;
  logic [2:0]              match_q, match_d, c_match;
  logic [CodeW-1:0]        code_q, code_d, c_code;
  logic [1:0]              digits_q, digits_d, c_digits;
  logic                    stopped_q, stopped_d, c_stopped;
  logic [LENGTH_WIDTH-1:0] name_q, name_d, c_name;
  logic [LENGTH_WIDTH-1:0] value_q, value_d, c_value;
  logic                    cr_q, cr_d, c_cr;
  err_e                    held_q, held_d, c_held;

  logic [7:0]  b;
  logic [7:0]  digit_diff;
  logic        is_digit;
  err_e        fail;
  out_beat_t   res;

  assign b          = beat_i.data_byte;
  assign digit_diff = b - CH_ZERO;
  assign is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);

  always_comb begin
    // A new message clears everything, a held error included, before the byte.
    if (beat_i.new_message) begin
      c_phase   = PH_VERSION;
      c_match   = '0;
      c_code    = '0;
      c_digits  = '0;
      c_stopped = 1'b0;
      c_name    = '0;
      c_value   = '0;
      c_cr      = 1'b0;
      c_held    = ERR_NONE;
    end else begin
      c_phase   = phase_q;
      c_match   = match_q;
      c_code    = code_q;
      c_digits  = digits_q;
      c_stopped = stopped_q;
      c_name    = name_q;
      c_value   = value_q;
      c_cr      = cr_q;
      c_held    = held_q;
    end

    phase_d   = c_phase;
    match_d   = c_match;
    code_d    = c_code;
    digits_d  = c_digits;
    stopped_d = c_stopped;
    name_d    = c_name;
    value_d   = c_value;
    cr_d      = c_cr;
    held_d    = c_held;

    res.byte_class   = CLS_AFTER_ERROR;
    res.event_res    = EV_NONE;
    res.error_kind   = ERR_NONE;
    res.status_code  = '0;
    res.name_length  = '0;
    res.value_length = '0;
    fail             = ERR_NONE;

    unique case (c_phase)
      PH_VERSION: begin
        res.byte_class = CLS_VERSION;
        if (c_match != 3'(VerPrefixLen)) begin
          if (b != ver_char(c_match)) begin
            fail = ERR_BAD_VERSION;
          end else begin
            match_d = c_match + 3'd1;
          end
        end else if (b == CH_ONE || b == CH_ZERO) begin
          match_d = '0;
          phase_d = PH_SP1;
        end else begin
          fail = ERR_BAD_VERSION;
        end
      end
      PH_SP1: begin
        res.byte_class = CLS_SPACE;
        if (b == CH_SP) begin
          phase_d   = PH_CODE;
          code_d    = '0;
          digits_d  = '0;
          stopped_d = 1'b0;
        end else begin
          fail = ERR_NO_SP_VERSION;
        end
      end
      PH_CODE: begin
        res.byte_class = CLS_CODE;
        // Accumulate leading digits only; the first non-digit freezes the code.
        if (!c_stopped && is_digit) begin
          code_d = {c_code[CodeW-4:0], 3'b000} + {c_code[CodeW-2:0], 1'b0}
                 + {{(CodeW-4){1'b0}}, digit_diff[3:0]};
        end else begin
          stopped_d = 1'b1;
        end
        if (c_digits >= 2'd2) begin
          phase_d = PH_SP2;
        end else begin
          digits_d = c_digits + 2'd1;
        end
      end
      PH_SP2: begin
        res.byte_class = CLS_SPACE;
        if (b == CH_SP) begin
          phase_d = PH_REASON;
          value_d = '0;
          cr_d    = 1'b0;
        end else begin
          fail = ERR_NO_SP_CODE;
        end
      end
      PH_REASON, PH_VALUE: begin
        if (c_cr) begin
          res.byte_class = CLS_LINE_END;
          if (b == CH_LF) begin
            cr_d             = 1'b0;
            res.value_length = OutLenW'(c_value);
            if (c_phase == PH_REASON) begin
              res.event_res   = EV_STATUS_DONE;
              res.status_code = c_code;
            end else begin
              res.event_res   = EV_FIELD_DONE;
              res.name_length = OutLenW'(c_name);
            end
            phase_d = PH_LINE;
            name_d  = '0;
            value_d = '0;
          end else begin
            fail = ERR_CR_NO_LF;
          end
        end else if (b == CH_CR) begin
          res.byte_class = CLS_LINE_END;
          cr_d           = 1'b1;
        end else begin
          res.byte_class = (c_phase == PH_REASON) ? CLS_REASON : CLS_VALUE;
          value_d        = (c_value == LenMax) ? c_value : c_value + 1'b1;
        end
      end
      PH_LINE: begin
        if (c_cr) begin
          res.byte_class = CLS_FINAL_CRLF;
          if (b == CH_LF) begin
            // End of head: back to the reset state for the next response.
            res.event_res = EV_HEADERS_DONE;
            phase_d   = PH_VERSION;
            match_d   = '0;
            code_d    = '0;
            digits_d  = '0;
            stopped_d = 1'b0;
            name_d    = '0;
            value_d   = '0;
            cr_d      = 1'b0;
            held_d    = ERR_NONE;
          end else begin
            fail = ERR_CR_NO_LF;
          end
        end else if (b == CH_CR) begin
          res.byte_class = CLS_FINAL_CRLF;
          cr_d           = 1'b1;
        end else if (b == CH_COLON) begin
          res.byte_class = CLS_COLON;
          name_d         = '0;
          phase_d        = PH_COLON_SP;
        end else begin
          res.byte_class = CLS_NAME;
          name_d         = {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
          phase_d        = PH_NAME;
        end
      end
      PH_NAME: begin
        if (b == CH_COLON) begin
          res.byte_class = CLS_COLON;
          phase_d        = PH_COLON_SP;
        end else begin
          res.byte_class = CLS_NAME;
          name_d         = (c_name == LenMax) ? c_name : c_name + 1'b1;
        end
      end
      PH_COLON_SP: begin
        res.byte_class = CLS_SPACE;
        if (b == CH_SP) begin
          phase_d = PH_VALUE;
          value_d = '0;
          cr_d    = 1'b0;
        end else begin
          fail = ERR_NO_SP_COLON;
        end
      end
      default: begin
        res.byte_class = CLS_AFTER_ERROR;
        res.error_kind = c_held;
      end
    endcase

    if (fail != ERR_NONE) begin
      held_d           = fail;
      phase_d          = PH_ERROR;
      res.byte_class   = CLS_AFTER_ERROR;
      res.event_res    = EV_ERROR;
      res.error_kind   = fail;
      res.status_code  = '0;
      res.name_length  = '0;
      res.value_length = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_VERSION;
      match_q   <= '0;
      code_q    <= '0;
      digits_q  <= '0;
      stopped_q <= 1'b0;
      name_q    <= '0;
      value_q   <= '0;
      cr_q      <= 1'b0;
      held_q    <= ERR_NONE;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      match_q   <= match_d;
      code_q    <= code_d;
      digits_q  <= digits_d;
      stopped_q <= stopped_d;
      name_q    <= name_d;
      value_q   <= value_d;
      cr_q      <= cr_d;
      held_q    <= held_d;
    end
  end

  assign res_o = res;

  `HRHP_ASSERT_NOW(a_error_phase_has_kind, phase_q == PH_ERROR, held_q != ERR_NONE, "error phase without a held error kind")
  `HRHP_ASSERT_NEXT(a_error_enters_phase, fire_i && res.event_res == EV_ERROR, phase_q == PH_ERROR, "error event did not enter the error phase")
  `HRHP_ASSERT_NEXT(a_code_three_bytes, fire_i && !beat_i.new_message && phase_q == PH_CODE && digits_q == 2'd2, phase_q == PH_SP2, "status code did not end after three bytes")

endmodule

>>> hw/rtl/hrhp_out_reg.sv
// Result register stage that holds one result beat until the sink takes it.
`timescale 1ns / 1ps
module hrhp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  hrhp_pkg::out_beat_t  res_i,
  output logic                free_o,
  output logic                valid_o,
  input  logic                ready_i,
  output hrhp_pkg::out_beat_t  res_o
);
  import hrhp_pkg::*;

  logic      valid_q, valid_d;
  out_beat_t res_q;

  // A new result may enter when the register is empty or is being drained.
  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> hw/rtl/http_response_head_parser.sv
// Top level of the HTTP response head parser: one result beat per byte beat.
// A byte waits in the input register, then its result beat is held in the result register.
// One byte per cycle while the sink takes result beats; the parse step is combinational.
// Reset (rst_ni low, asynchronous) empties both stages and sets the parser to await a version.
`timescale 1ns / 1ps
module http_response_head_parser #(
  parameter int unsigned LENGTH_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  hrhp_in_if.sink          in_i,
  hrhp_out_if.source       out_o
);
  import hrhp_pkg::*;
  `include "http_response_head_parser_assert.svh"

  in_beat_t  in_beat, reg_beat;
  out_beat_t step_res, out_res;
  logic      reg_valid;
  logic      out_free;
  logic      adv;

  assign in_beat.data_byte   = in_i.data_byte;
  assign in_beat.new_message = in_i.new_message;

  // A byte is processed when it sits in the input register and the result slot is free.
  assign adv = reg_valid && out_free;

  hrhp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .beat_i  (in_beat),
    .adv_i   (adv),
    .valid_o (reg_valid),
    .beat_o  (reg_beat)
  );

  hrhp_core #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv),
    .beat_i (reg_beat),
    .res_o  (step_res)
  );

  hrhp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv),
    .res_i   (step_res),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_res)
  );

  assign out_o.byte_class   = out_res.byte_class;
  assign out_o.event_res    = out_res.event_res;
  assign out_o.error_kind   = out_res.error_kind;
  assign out_o.status_code  = out_res.status_code;
  assign out_o.name_length  = out_res.name_length;
  assign out_o.value_length = out_res.value_length;

  `HRHP_ASSERT_NOW(a_err_iff_after_error, out_o.valid, (out_res.byte_class == CLS_AFTER_ERROR) == (out_res.error_kind != ERR_NONE), "error kind disagrees with byte class")
  `HRHP_ASSERT_NOW(a_code_only_on_status, out_o.valid && out_res.event_res != EV_STATUS_DONE, out_res.status_code == '0, "status code shown outside status line done")
  `HRHP_ASSERT_NOW(a_name_only_on_field, out_o.valid && out_res.event_res != EV_FIELD_DONE, out_res.name_length == '0, "name length shown outside field done")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the HTTP response head parser: random heads, damage and stalls.
`timescale 1ns / 1ps
module testbench;
  import hrhp_pkg::*;

  localparam int unsigned LEN_W      = 16;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam logic [55:0] VER_HEAD   = "HTTP/1.";

  typedef enum int unsigned {
    DMG_NONE,
    DMG_OVERWRITE,
    DMG_STRAY_CR,
    DMG_TRUNCATE
  } damage_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  hrhp_in_if  in_ch ();
  hrhp_out_if out_ch ();

  http_response_head_parser #(.LENGTH_WIDTH(LEN_W)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  in_beat_t    byte_feed[$];
  out_beat_t   tags_due[$];
  out_beat_t   tag_seen;
  logic [7:0]  head_bytes[$];
  int unsigned key_spots[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_gap, out_stall;
  int unsigned calm_in = 0, calm_out = 0;

  // Parser state as predicted from the byte stream.
  phase_e           parse_phase;
  logic [2:0]       ver_pos;
  logic [CodeW-1:0] code_acc;
  logic [1:0]       code_cnt;
  logic             code_halt;
  logic [LEN_W-1:0] name_cnt, val_cnt;
  logic             cr_seen;
  err_e             held_err;

  function automatic void clear_parser();
    parse_phase = PH_VERSION;
    ver_pos     = '0;
    code_acc    = '0;
    code_cnt    = '0;
    code_halt   = 1'b0;
    name_cnt    = '0;
    val_cnt     = '0;
    cr_seen     = 1'b0;
    held_err    = ERR_NONE;
  endfunction

  function automatic out_beat_t tag_byte(logic [7:0] b, logic fresh);
    out_beat_t t;
    err_e      fail;
    t.byte_class   = CLS_AFTER_ERROR;
    t.event_res    = EV_NONE;
    t.error_kind   = ERR_NONE;
    t.status_code  = '0;
    t.name_length  = '0;
    t.value_length = '0;
    fail = ERR_NONE;
    if (fresh) clear_parser();
    case (parse_phase)
      PH_VERSION: begin
        t.byte_class = CLS_VERSION;
        if (ver_pos < 3'd7) begin
          if (b != VER_HEAD[8*(6-ver_pos) +: 8]) fail = ERR_BAD_VERSION;
          else ver_pos = ver_pos + 3'd1;
        end else if (b == CH_ONE || b == CH_ZERO) begin
          ver_pos     = '0;
          parse_phase = PH_SP1;
        end else begin
          fail = ERR_BAD_VERSION;
        end
      end
      PH_SP1: begin
        t.byte_class = CLS_SPACE;
        if (b == CH_SP) begin
          parse_phase = PH_CODE;
          code_acc    = '0;
          code_cnt    = '0;
          code_halt   = 1'b0;
        end else begin
          fail = ERR_NO_SP_VERSION;
        end
      end
      PH_CODE: begin
        t.byte_class = CLS_CODE;
        // The first non-digit freezes the code; the remaining code bytes are still consumed.
        if (!code_halt && b >= CH_ZERO && b <= CH_NINE)
          code_acc = CodeW'(code_acc * 10 + (b - CH_ZERO));
        else code_halt = 1'b1;
        if (code_cnt >= 2'd2) parse_phase = PH_SP2;
        else code_cnt = code_cnt + 2'd1;
      end
      PH_SP2: begin
        t.byte_class = CLS_SPACE;
        if (b == CH_SP) begin
          parse_phase = PH_REASON;
          val_cnt     = '0;
          cr_seen     = 1'b0;
        end else begin
          fail = ERR_NO_SP_CODE;
        end
      end
      PH_REASON, PH_VALUE: begin
        if (cr_seen) begin
          t.byte_class = CLS_LINE_END;
          if (b == CH_LF) begin
            cr_seen        = 1'b0;
            t.value_length = val_cnt[OutLenW-1:0];
            if (parse_phase == PH_REASON) begin
              t.event_res   = EV_STATUS_DONE;
              t.status_code = code_acc;
            end else begin
              t.event_res   = EV_FIELD_DONE;
              t.name_length = name_cnt[OutLenW-1:0];
            end
            parse_phase = PH_LINE;
            name_cnt    = '0;
            val_cnt     = '0;
          end else begin
            fail = ERR_CR_NO_LF;
          end
        end else if (b == CH_CR) begin
          t.byte_class = CLS_LINE_END;
          cr_seen      = 1'b1;
        end else begin
          if (parse_phase == PH_REASON) t.byte_class = CLS_REASON;
          else t.byte_class = CLS_VALUE;
          if (val_cnt != {LEN_W{1'b1}}) val_cnt = val_cnt + 1'b1;
        end
      end
      PH_LINE: begin
        if (cr_seen) begin
          t.byte_class = CLS_FINAL_CRLF;
          if (b == CH_LF) begin
            t.event_res = EV_HEADERS_DONE;
            clear_parser();
          end else begin
            fail = ERR_CR_NO_LF;
          end
        end else if (b == CH_CR) begin
          t.byte_class = CLS_FINAL_CRLF;
          cr_seen      = 1'b1;
        end else if (b == CH_COLON) begin
          t.byte_class = CLS_COLON;
          name_cnt     = '0;
          parse_phase  = PH_COLON_SP;
        end else begin
          t.byte_class = CLS_NAME;
          name_cnt     = LEN_W'(1);
          parse_phase  = PH_NAME;
        end
      end
      PH_NAME: begin
        if (b == CH_COLON) begin
          t.byte_class = CLS_COLON;
          parse_phase  = PH_COLON_SP;
        end else begin
          t.byte_class = CLS_NAME;
          if (name_cnt != {LEN_W{1'b1}}) name_cnt = name_cnt + 1'b1;
        end
      end
      PH_COLON_SP: begin
        t.byte_class = CLS_SPACE;
        if (b == CH_SP) begin
          parse_phase = PH_VALUE;
          val_cnt     = '0;
          cr_seen     = 1'b0;
        end else begin
          fail = ERR_NO_SP_COLON;
        end
      end
      default: begin
        t.error_kind = held_err;
      end
    endcase
    if (fail != ERR_NONE) begin
      held_err       = fail;
      parse_phase    = PH_ERROR;
      t.byte_class   = CLS_AFTER_ERROR;
      t.event_res    = EV_ERROR;
      t.error_kind   = fail;
      t.status_code  = '0;
      t.name_length  = '0;
      t.value_length = '0;
    end
    return t;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 5) begin
      calm = $urandom_range(50, 400);
      return 0;
    end
    if (r < 600) return 0;
    if (r < 900) return $urandom_range(1, 3);
    if (r < 990) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte_not(logic [7:0] a, logic [7:0] c);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == a || b == c);
    return b;
  endfunction

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) head_bytes.push_back(s[i]);
  endfunction

  // Builds a well-formed head with random content and notes the bytes worth damaging.
  function automatic void make_head();
    int unsigned len;
    head_bytes.delete();
    key_spots.delete();
    append_text("HTTP/1.");
    key_spots.push_back(head_bytes.size());
    head_bytes.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
    key_spots.push_back(head_bytes.size());
    head_bytes.push_back(CH_SP);
    repeat (3) begin
      if ($urandom_range(0, 9) != 0) head_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      else head_bytes.push_back(8'($urandom_range(0, 255)));
    end
    key_spots.push_back(head_bytes.size());
    head_bytes.push_back(CH_SP);
    len = $urandom_range(0, 12);
    repeat (len) head_bytes.push_back(rand_byte_not(CH_CR, CH_CR));
    head_bytes.push_back(CH_CR);
    key_spots.push_back(head_bytes.size());
    head_bytes.push_back(CH_LF);
    repeat ($urandom_range(0, 4)) begin
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        if (i == 0) head_bytes.push_back(rand_byte_not(CH_COLON, CH_CR));
        else head_bytes.push_back(rand_byte_not(CH_COLON, CH_COLON));
      end
      head_bytes.push_back(CH_COLON);
      key_spots.push_back(head_bytes.size());
      head_bytes.push_back(CH_SP);
      len = $urandom_range(0, 8);
      repeat (len) head_bytes.push_back(rand_byte_not(CH_CR, CH_CR));
      head_bytes.push_back(CH_CR);
      key_spots.push_back(head_bytes.size());
      head_bytes.push_back(CH_LF);
    end
    head_bytes.push_back(CH_CR);
    key_spots.push_back(head_bytes.size());
    head_bytes.push_back(CH_LF);
  endfunction

  function automatic void send_head(bit fresh, damage_e damage);
    int unsigned pos;
    pos = $urandom_range(0, head_bytes.size() - 1);
    if (damage == DMG_OVERWRITE && key_spots.size() != 0 && $urandom_range(0, 1) != 0)
      pos = key_spots[$urandom_range(0, key_spots.size() - 1)];
    case (damage)
      DMG_OVERWRITE: head_bytes[pos] = 8'($urandom_range(0, 255));
      DMG_STRAY_CR:  head_bytes.insert(pos, CH_CR);
      DMG_TRUNCATE:  while (head_bytes.size() > pos + 1) void'(head_bytes.pop_back());
      default: ;
    endcase
    foreach (head_bytes[i])
      byte_feed.push_back('{data_byte: head_bytes[i], new_message: fresh && (i == 0)});
  endfunction

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  // Byte driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.data_byte   <= '0;
      in_ch.new_message <= 1'b0;
      in_gap            <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap != 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (byte_feed.size() != 0) begin
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= byte_feed[0].data_byte;
        in_ch.new_message <= byte_feed[0].new_message;
        void'(byte_feed.pop_front());
        in_gap            <= pick_gap(calm_in);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else if (out_stall != 0) begin
      out_ch.ready <= 1'b0;
      out_stall    <= out_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall <= pick_gap(calm_out);
    end
  end

  // Monitor: checks each result beat, predicts each accepted byte, and guards against hangs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (tags_due.size() == 0) begin
          $error("result beat with no byte outstanding");
          mismatches++;
        end else begin
          tag_seen = tags_due.pop_front();
          check_field("byte_class", 16'(tag_seen.byte_class), 16'(out_ch.byte_class));
          check_field("event_res", 16'(tag_seen.event_res), 16'(out_ch.event_res));
          check_field("error_kind", 16'(tag_seen.error_kind), 16'(out_ch.error_kind));
          check_field("status_code", 16'(tag_seen.status_code), 16'(out_ch.status_code));
          check_field("name_length", tag_seen.name_length, out_ch.name_length);
          check_field("value_length", tag_seen.value_length, out_ch.value_length);
        end
      end
      if (in_ch.valid && in_ch.ready)
        tags_due.push_back(tag_byte(in_ch.data_byte, in_ch.new_message));
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("testbench: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned pick;
    bit          last_bad;
    damage_e     dmg;
    rst_ni = 1'b0;
    clear_parser();

    // Code cut short by a non-digit, empty reason, empty name and value, then the end of the head.
    head_bytes.delete();
    append_text("HTTP/1.0 2x9 \015\012: \015\012\015\012");
    send_head(1'b1, DMG_NONE);
    // Extreme bytes: a bad version, then a byte taken while the error is held.
    head_bytes.delete();
    head_bytes.push_back(8'hFF);
    head_bytes.push_back(8'h00);
    send_head(1'b1, DMG_NONE);

    random_items = 0;
    last_bad     = 1'b1;
    while (random_items < 850) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        head_bytes.delete();
        repeat ($urandom_range(1, 10)) head_bytes.push_back(8'($urandom_range(0, 255)));
        send_head(1'($urandom_range(0, 1)), DMG_NONE);
        last_bad = 1'b1;
      end else begin
        make_head();
        if (pick < 72) dmg = DMG_NONE;
        else dmg = damage_e'($urandom_range(DMG_OVERWRITE, DMG_TRUNCATE));
        send_head(last_bad || ($urandom_range(0, 1) != 0), dmg);
        last_bad = (dmg != DMG_NONE);
      end
      random_items += head_bytes.size();
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (byte_feed.size() != 0 || in_ch.valid || tags_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hrhp_pkg.sv
hw/rtl/hrhp_if.sv
hw/rtl/hrhp_in_reg.sv
hw/rtl/hrhp_core.sv
hw/rtl/hrhp_out_reg.sv
hw/rtl/http_response_head_parser.sv
tb/testbench.sv
